### rtl/core/frame_animation_sequencer_core_assert.svh
// assertion macros for the frame animation sequencer core
`ifndef FRAME_ANIMATION_SEQUENCER_CORE_ASSERT_SVH
`define FRAME_ANIMATION_SEQUENCER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define FAS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fas: same-cycle check failed");

// next-cycle implication, checked out of reset
`define FAS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fas: next-cycle check failed");

`endif

### rtl/core/fas_pkg.sv
// shared types, constants and frame fold function of the frame animation sequencer
package fas_pkg;

    localparam int MAX_FRAMES = 16;
    localparam int FRAME_W    = 4;
    localparam int CNT_W      = 5;
    localparam int ACC_W      = 32;
    localparam int DELAY_W    = 16;
    localparam int STEP_W     = 16;
    localparam int PASSED_W   = 16;
    localparam int ACTION_W   = 2;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;
    localparam int SUM_W      = ACC_W + 2;

    localparam logic [ACC_W-1:0]    ACC_MAX    = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0]    ACC_MIN    = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [PASSED_W-1:0] PASSED_SAT = {PASSED_W{1'b1}};

    // item opcodes
    typedef enum logic [ACTION_W-1:0] {
        ACT_ADVANCE     = 2'd0,
        ACT_WRITE_DELAY = 2'd1,
        ACT_SET_FRAME   = 2'd2,
        ACT_RESTART     = 2'd3
    } t_action;

    // configuration register indexes (byte address 4*i)
    localparam logic [1:0] REG_LOOP_ENABLE   = 2'd0;
    localparam logic [1:0] REG_PINGPONG_MODE = 2'd1;
    localparam logic [1:0] REG_FRAME_COUNT   = 2'd2;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic               dir_down;
    } t_fold;

    // bring a stepped frame (range -1 .. MAX_FRAMES) back into range
    function automatic t_fold fold_frame(
        input logic signed [FRAME_W+1:0] f,
        input logic [CNT_W-1:0]          n,
        input logic                      loop_en,
        input logic                      pp,
        input logic                      dir_in
    );
        t_fold             r;
        logic              below;
        logic              above;
        logic              single;
        logic [CNT_W-1:0]  last;
        logic [CNT_W-1:0]  second_last;
        below       = f[FRAME_W+1];
        above       = !below && (f[FRAME_W:0] >= n);
        single      = (n == CNT_W'(1));
        last        = n - CNT_W'(1);
        second_last = n - CNT_W'(2);
        r.frame     = f[FRAME_W-1:0];
        r.dir_down  = dir_in;
        if (!pp) begin
            if (loop_en) begin
                if (below) r.frame = last[FRAME_W-1:0];
                else if (above) r.frame = '0;
            end else begin
                if (above) r.frame = last[FRAME_W-1:0];
                else if (below) r.frame = '0;
            end
        end else begin
            if (loop_en) begin
                if (below) begin
                    r.frame    = single ? '0 : FRAME_W'(1);
                    r.dir_down = 1'b0;
                end else if (above) begin
                    r.frame    = single ? '0 : second_last[FRAME_W-1:0];
                    r.dir_down = 1'b1;
                end
            end else begin
                if (above) begin
                    r.frame    = last[FRAME_W-1:0];
                    r.dir_down = 1'b1;
                end else if (below) begin
                    r.frame = '0;
                end
            end
        end
        return r;
    endfunction

endpackage

### rtl/core/frame_animation_sequencer_core.sv
// frame animation sequencer: delay table, frame walk sequencer and config port
`include "frame_animation_sequencer_core_assert.svh"

// One item in, one result out. Write delay, set frame and restart items are
// done in the accept cycle and their result passes through the done state
// into the output register. An advance item first adds its signed step to
// the saturating 32-bit accumulator, then walks one frame per cycle through
// a single shared 34-bit adder that subtracts the delay of the frame at hand
// going forward or adds the delay of the frame stepped to going backward. A
// zero delay ends the walk early, and a one-shot end or a single frame ends
// a forward walk early. A result that finds the output register still full
// waits for it. Input ready is high only while the sequencer is idle; a
// finished result waits in the output register and the next item may be
// accepted while it is not yet taken.
// Delay entries hold no reset value and must be written before use.
module frame_animation_sequencer_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input item channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [fas_pkg::ACTION_W-1:0]    i_action,
    input  logic signed [fas_pkg::STEP_W-1:0] i_time_step,
    input  logic [fas_pkg::FRAME_W-1:0]     i_frame_index,
    input  logic [fas_pkg::DELAY_W-1:0]     i_delay_value,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [fas_pkg::PASSED_W-1:0]    o_frames_passed,
    output logic [fas_pkg::FRAME_W-1:0]     o_current_frame_out,
    output logic                            o_moving_backward,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fas_pkg::PADDR_W-1:0]     paddr,
    input  logic [fas_pkg::PDATA_W-1:0]     pwdata,
    output logic [fas_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_FWD,
        S_BWD,
        S_DONE
    } t_state;

    t_state                               r_state;
    logic [fas_pkg::ACC_W-1:0]            r_acc;
    logic [fas_pkg::FRAME_W-1:0]          r_cur;
    logic                                 r_dir;
    logic [fas_pkg::PASSED_W-1:0]         r_passed;
    logic signed [fas_pkg::STEP_W-1:0]    r_step;
    logic                                 r_out_valid;
    logic [fas_pkg::PASSED_W-1:0]         r_out_passed;
    logic [fas_pkg::FRAME_W-1:0]          r_out_frame;
    logic                                 r_out_dir;
    logic                                 r_loop;
    logic                                 r_pp;
    logic [fas_pkg::CNT_W-1:0]            r_frame_count;
    logic [fas_pkg::DELAY_W-1:0]          r_delay [fas_pkg::MAX_FRAMES];

    logic                                 in_fire;
    logic                                 cfg_wr;
    logic [fas_pkg::CNT_W-1:0]            frames_used;
    logic [fas_pkg::CNT_W-1:0]            last_frame;
    logic                                 step_up;
    logic signed [fas_pkg::FRAME_W+1:0]   moved;
    fas_pkg::t_fold                       folded;
    logic [fas_pkg::DELAY_W-1:0]          d_cur;
    logic [fas_pkg::DELAY_W-1:0]          d_moved;
    logic [fas_pkg::SUM_W-1:0]            op_a;
    logic [fas_pkg::SUM_W-1:0]            op_b;
    logic                                 carry_in;
    logic [fas_pkg::SUM_W-1:0]            sum;
    logic [fas_pkg::ACC_W-1:0]            acc_sat;
    logic                                 fwd_stop;
    logic [fas_pkg::PASSED_W-1:0]         passed_inc;
    logic [fas_pkg::FRAME_W-1:0]          set_frame;
    logic                                 out_free;

    assign in_fire    = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign out_free   = !r_out_valid || i_out_ready;

    // frames in use, clamped to 1 .. MAX_FRAMES
    always_comb begin
        frames_used = r_frame_count;
        if (r_frame_count == '0) begin
            frames_used = fas_pkg::CNT_W'(1);
        end else if (r_frame_count > fas_pkg::CNT_W'(fas_pkg::MAX_FRAMES)) begin
            frames_used = fas_pkg::CNT_W'(fas_pkg::MAX_FRAMES);
        end
    end
    assign last_frame = frames_used - fas_pkg::CNT_W'(1);

    // one frame step and fold; backward walk inverts the ping-pong sense
    assign step_up = (r_state == S_BWD) ? r_dir : !r_dir;
    assign moved   = step_up ? ($signed({2'b00, r_cur}) + 6'sd1)
                             : ($signed({2'b00, r_cur}) - 6'sd1);
    assign folded  = fas_pkg::fold_frame(moved, frames_used, r_loop, r_pp, r_dir);

    // delay lookups: frame at hand and frame after the step
    assign d_cur   = r_delay[r_cur];
    assign d_moved = r_delay[folded.frame];

    // shared adder: step add, delay add (backward) or delay subtract (forward)
    assign op_a = {{2{r_acc[fas_pkg::ACC_W-1]}}, r_acc};
    always_comb begin
        op_b     = '0;
        carry_in = 1'b0;
        case (r_state)
            S_ADD: op_b = {{(fas_pkg::SUM_W-fas_pkg::STEP_W){r_step[fas_pkg::STEP_W-1]}},
                           r_step};
            S_BWD: op_b = {{(fas_pkg::SUM_W-fas_pkg::DELAY_W){1'b0}}, d_moved};
            S_FWD: begin
                op_b     = ~{{(fas_pkg::SUM_W-fas_pkg::DELAY_W){1'b0}}, d_cur};
                carry_in = 1'b1;
            end
            default: op_b = '0;
        endcase
    end
    assign sum = op_a + op_b + {{(fas_pkg::SUM_W-1){1'b0}}, carry_in};

    // saturate the step add to the signed 32-bit range
    always_comb begin
        acc_sat = sum[fas_pkg::ACC_W-1:0];
        if (sum[fas_pkg::ACC_W] != sum[fas_pkg::ACC_W-1]) begin
            acc_sat = sum[fas_pkg::SUM_W-1] ? fas_pkg::ACC_MIN : fas_pkg::ACC_MAX;
        end
    end

    // forward walk ends: delay not reached, single frame or one-shot end
    assign fwd_stop = sum[fas_pkg::SUM_W-1]
                   || (frames_used == fas_pkg::CNT_W'(1))
                   || (!r_loop && !r_pp && ({1'b0, r_cur} == last_frame))
                   || (!r_loop && r_pp && r_dir && (r_cur == '0));

    assign passed_inc = (r_passed == fas_pkg::PASSED_SAT) ? r_passed
                                                          : r_passed + 1'b1;

    // set frame saturates to the last frame in use
    assign set_frame = ({1'b0, i_frame_index} >= frames_used)
                     ? last_frame[fas_pkg::FRAME_W-1:0] : i_frame_index;

    // sequencer, walk state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc       <= '0;
            r_cur       <= '0;
            r_dir       <= 1'b0;
            r_passed    <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // result taken and no new one landing this cycle
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_passed <= '0;
                        r_step   <= i_time_step;
                        unique case (fas_pkg::t_action'(i_action))
                            fas_pkg::ACT_ADVANCE: r_state <= S_ADD;
                            fas_pkg::ACT_WRITE_DELAY: r_state <= S_DONE;
                            fas_pkg::ACT_SET_FRAME: begin
                                r_cur   <= set_frame;
                                r_state <= S_DONE;
                            end
                            fas_pkg::ACT_RESTART: begin
                                r_cur   <= '0;
                                r_acc   <= '0;
                                r_dir   <= 1'b0;
                                r_state <= S_DONE;
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_ADD: begin
                    r_acc   <= acc_sat;
                    r_state <= r_step[fas_pkg::STEP_W-1] ? S_BWD : S_FWD;
                end
                S_BWD: begin
                    if (!r_acc[fas_pkg::ACC_W-1]) begin
                        r_state <= S_DONE;
                    end else begin
                        r_passed <= passed_inc;
                        r_cur    <= folded.frame;
                        r_dir    <= folded.dir_down;
                        r_acc    <= sum[fas_pkg::ACC_W-1:0];
                        if (d_moved == '0) r_state <= S_DONE;
                    end
                end
                S_FWD: begin
                    if (fwd_stop || (d_cur == '0)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_acc    <= sum[fas_pkg::ACC_W-1:0];
                        r_passed <= passed_inc;
                        r_cur    <= folded.frame;
                        r_dir    <= folded.dir_down;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_passed <= r_passed;
                        r_out_frame  <= r_cur;
                        r_out_dir    <= r_dir;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // delay table, written by write delay items
    always_ff @(posedge i_clk) begin
        if (in_fire && (fas_pkg::t_action'(i_action) == fas_pkg::ACT_WRITE_DELAY)) begin
            r_delay[i_frame_index] <= i_delay_value;
        end
    end

    // configuration registers
    assign cfg_wr = psel && penable && pwrite && pready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loop        <= 1'b1;
            r_pp          <= 1'b0;
            r_frame_count <= fas_pkg::CNT_W'(1);
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                fas_pkg::REG_LOOP_ENABLE:   r_loop        <= pwdata[0];
                fas_pkg::REG_PINGPONG_MODE: r_pp          <= pwdata[0];
                fas_pkg::REG_FRAME_COUNT:   r_frame_count <= pwdata[fas_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (paddr[3:2])
            fas_pkg::REG_LOOP_ENABLE:
                prdata = {{(fas_pkg::PDATA_W-1){1'b0}}, r_loop};
            fas_pkg::REG_PINGPONG_MODE:
                prdata = {{(fas_pkg::PDATA_W-1){1'b0}}, r_pp};
            fas_pkg::REG_FRAME_COUNT:
                prdata = {{(fas_pkg::PDATA_W-fas_pkg::CNT_W){1'b0}}, r_frame_count};
            default: prdata = '0;
        endcase
    end
    assign pready = 1'b1;

    assign o_out_valid         = r_out_valid;
    assign o_frames_passed     = r_out_passed;
    assign o_current_frame_out = r_out_frame;
    assign o_moving_backward   = r_out_dir;

    // non-advance items go straight to the result stage
    `FAS_ASSERT_NEXT(a_nonadv_done, in_fire && (i_action != fas_pkg::ACT_ADVANCE), r_state == S_DONE)
    // a saturated frame count stays saturated through the walk
    `FAS_ASSERT_NEXT(a_passed_sat, ((r_state == S_FWD) || (r_state == S_BWD)) && (r_passed == fas_pkg::PASSED_SAT), r_passed == fas_pkg::PASSED_SAT)
    // a finished item lands in the output register once it is free
    `FAS_ASSERT_NEXT(a_done_out, (r_state == S_DONE) && out_free, r_out_valid && (r_state == S_IDLE))

endmodule

### verif/frame_animation_sequencer_core_test.sv
// testbench for the frame animation sequencer core: directed and random items against a frame walk predictor
`timescale 1ns / 1ps

module frame_animation_sequencer_core_test;

    localparam int     WALK_BUDGET = 300;
    localparam int     HOLD_CYCLES = 400;
    localparam int     DRAIN_PAUSE = 8;
    localparam longint ACC_HI      = 64'sd2147483647;
    localparam longint ACC_LO      = -64'sd2147483648;

    typedef struct packed {
        logic [fas_pkg::PASSED_W-1:0] passed;
        logic [fas_pkg::FRAME_W-1:0]  frame;
        logic                         down;
    } t_frame_result;

    // block ports
    logic                              i_clk         = 1'b0;
    logic                              i_rst_n       = 1'b0;
    logic                              i_in_valid    = 1'b0;
    logic                              o_in_ready;
    logic [fas_pkg::ACTION_W-1:0]      i_action      = '0;
    logic signed [fas_pkg::STEP_W-1:0] i_time_step   = '0;
    logic [fas_pkg::FRAME_W-1:0]       i_frame_index = '0;
    logic [fas_pkg::DELAY_W-1:0]       i_delay_value = '0;
    logic                              o_out_valid;
    logic                              i_out_ready   = 1'b0;
    logic [fas_pkg::PASSED_W-1:0]      o_frames_passed;
    logic [fas_pkg::FRAME_W-1:0]       o_current_frame_out;
    logic                              o_moving_backward;
    logic                              psel          = 1'b0;
    logic                              penable       = 1'b0;
    logic                              pwrite        = 1'b0;
    logic [fas_pkg::PADDR_W-1:0]       paddr         = '0;
    logic [fas_pkg::PDATA_W-1:0]       pwdata        = '0;
    logic [fas_pkg::PDATA_W-1:0]       prdata;
    logic                              pready;

    // predictor state and configuration
    logic [fas_pkg::DELAY_W-1:0] delay_model [fas_pkg::MAX_FRAMES];
    int                          frame_model;
    int                          acc_model;
    bit                          down_model;
    bit                          loop_model;
    bit                          pingpong_model;
    logic [fas_pkg::CNT_W-1:0]   count_model;

    t_frame_result      expected_frames [$];
    int                 mismatch_count;
    bit                 idle_on;
    bit                 hold_request;

    frame_animation_sequencer_core dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_action            (i_action),
        .i_time_step         (i_time_step),
        .i_frame_index       (i_frame_index),
        .i_delay_value       (i_delay_value),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_frames_passed     (o_frames_passed),
        .o_current_frame_out (o_current_frame_out),
        .o_moving_backward   (o_moving_backward),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    // clock
    always #10 i_clk = ~i_clk;

    // run limit
    initial begin
        #200_000_000;
        $display("frame_animation_sequencer_core_test failed");
        $finish;
    end

    // frames in use, with zero taken as one and the count capped at the table size
    function automatic int frames_in_use();
        if (count_model == '0) return 1;
        if (count_model > fas_pkg::MAX_FRAMES) return fas_pkg::MAX_FRAMES;
        return int'(count_model);
    endfunction

    function automatic longint delay_of(input int f);
        if (f < 0 || f >= fas_pkg::MAX_FRAMES) return 0;
        return {48'd0, delay_model[f]};
    endfunction

    // bring a stepped frame back into range by the active mode
    function automatic void fold_into_range(inout int f, inout bit dn, input int n);
        if (!pingpong_model) begin
            if (loop_model) begin
                if (f < 0) f = n - 1;
                else if (f >= n) f = 0;
            end else begin
                if (f >= n) f = n - 1;
                else if (f < 0) f = 0;
            end
        end else if (loop_model) begin
            if (f < 0) begin
                f  = (n == 1) ? 0 : 1;
                dn = 1'b0;
            end else if (f >= n) begin
                f  = (n == 1) ? n - 1 : n - 2;
                dn = 1'b1;
            end
        end else begin
            if (f >= n) begin
                f  = n - 1;
                dn = 1'b1;
            end else if (f < 0) begin
                f = 0;
            end
        end
    endfunction

    // walk frames for one advance, returns frames walked (counting stops past limit)
    function automatic int walk_frames(input int step, input int limit, inout int f,
                                       inout longint acc, inout bit dn);
        int     n;
        int     walked;
        longint d;
        bit     was_down;
        n      = frames_in_use();
        walked = 0;
        acc    = acc + step;
        if (acc > ACC_HI) acc = ACC_HI;
        if (acc < ACC_LO) acc = ACC_LO;
        if (step < 0) begin
            // backward: step back until the accumulator is no longer negative or a zero delay is met
            while (acc < 0 && walked <= limit) begin
                walked++;
                f = dn ? f + 1 : f - 1;
                fold_into_range(f, dn, n);
                d   = delay_of(f);
                acc = acc + d;
                if (d == 0) break;
            end
        end else begin
            // forward: consume the delay of the frame at hand
            d = delay_of(f);
            while (acc >= d && walked <= limit) begin
                was_down = dn;
                if (n == 1) break;
                if (!loop_model && !pingpong_model && f == n - 1) break;
                if (!loop_model && pingpong_model && was_down && f == 0) break;
                acc = acc - d;
                if (d == 0) break;
                walked++;
                if (loop_model || !pingpong_model || !was_down || f > 0)
                    f = was_down ? f - 1 : f + 1;
                fold_into_range(f, dn, n);
                d = delay_of(f);
            end
        end
        return walked;
    endfunction

    // frames an advance would walk from the present state, capped just past the budget
    function automatic int trial_walk(input int step);
        int     f;
        longint acc;
        bit     dn;
        f   = frame_model;
        acc = acc_model;
        dn  = down_model;
        return walk_frames(step, WALK_BUDGET, f, acc, dn);
    endfunction

    // apply one accepted item to the predictor and return the result it gives
    function automatic t_frame_result predict_frame_state(
        input fas_pkg::t_action            act,
        input int                          step,
        input logic [fas_pkg::FRAME_W-1:0] idx,
        input logic [fas_pkg::DELAY_W-1:0] dval
    );
        t_frame_result r;
        longint        acc;
        int            walked;
        int            n;
        r.passed = '0;
        case (act)
            fas_pkg::ACT_ADVANCE: begin
                acc       = acc_model;
                walked    = walk_frames(step, 32'h7FFF_FFFF, frame_model, acc, down_model);
                acc_model = int'(acc);
                r.passed  = (walked > 65535) ? fas_pkg::PASSED_SAT
                                             : fas_pkg::PASSED_W'(walked);
            end
            fas_pkg::ACT_WRITE_DELAY: begin
                delay_model[idx] = dval;
            end
            fas_pkg::ACT_SET_FRAME: begin
                n           = frames_in_use();
                frame_model = (int'(idx) >= n) ? n - 1 : int'(idx);
            end
            default: begin
                frame_model = 0;
                acc_model   = 0;
                down_model  = 1'b0;
            end
        endcase
        r.frame = frame_model[fas_pkg::FRAME_W-1:0];
        r.down  = down_model;
        return r;
    endfunction

    // gap length: mostly short, a few long
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 2);
        if (r < 93) return $urandom_range(3, 8);
        return $urandom_range(12, 40);
    endfunction

    // present one item and hold it until accepted
    task automatic send_item(input fas_pkg::t_action act,
                             input logic signed [fas_pkg::STEP_W-1:0] step,
                             input logic [fas_pkg::FRAME_W-1:0] idx,
                             input logic [fas_pkg::DELAY_W-1:0] dval);
        int            gap;
        t_frame_result want;
        gap = (idle_on && $urandom_range(0, 2) == 0) ? idle_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_action      <= act;
        i_time_step   <= step;
        i_frame_index <= idx;
        i_delay_value <= dval;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        want = predict_frame_state(act, step, idx, dval);
        expected_frames.insert(expected_frames.size(), want);
    endtask

    // stop offering items and wait until every result is back
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (expected_frames.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAUSE) @(posedge i_clk);
    endtask

    // one register access; for a read, data is the value the register should hold
    task automatic apb_transfer(input bit write, input logic [1:0] reg_index,
                                input logic [fas_pkg::PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= fas_pkg::PADDR_W'({reg_index, 2'b00});
        pwdata  <= write ? data : '0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (!write && prdata !== data) begin
            $error("register %0d: expected %0h, actual %0h", reg_index, data, prdata);
            mismatch_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_register(input logic [1:0] reg_index,
                                input logic [fas_pkg::PDATA_W-1:0] value);
        logic [fas_pkg::PDATA_W-1:0] held;
        apb_transfer(1'b1, reg_index, value);
        case (reg_index)
            fas_pkg::REG_LOOP_ENABLE: begin
                loop_model = value[0];
                held       = {31'd0, loop_model};
            end
            fas_pkg::REG_PINGPONG_MODE: begin
                pingpong_model = value[0];
                held           = {31'd0, pingpong_model};
            end
            default: begin
                count_model = value[fas_pkg::CNT_W-1:0];
                held        = fas_pkg::PDATA_W'(count_model);
            end
        endcase
        apb_transfer(1'b0, reg_index, held);
    endtask

    // new play mode, written only once the block is idle
    task automatic configure(input bit loop_en, input bit pingpong,
                             input logic [fas_pkg::CNT_W-1:0] count);
        wait_for_results();
        set_register(fas_pkg::REG_LOOP_ENABLE, fas_pkg::PDATA_W'(loop_en));
        set_register(fas_pkg::REG_PINGPONG_MODE, fas_pkg::PDATA_W'(pingpong));
        set_register(fas_pkg::REG_FRAME_COUNT, fas_pkg::PDATA_W'(count));
    endtask

    // random item, advances shrunk or replaced by a restart when the walk would run long
    task automatic send_random_item();
        int                                r;
        int                                tries;
        fas_pkg::t_action                  act;
        logic signed [fas_pkg::STEP_W-1:0] step;
        logic [fas_pkg::FRAME_W-1:0]       idx;
        logic [fas_pkg::DELAY_W-1:0]       dval;
        r = $urandom_range(0, 99);
        if (r < 55) act = fas_pkg::ACT_ADVANCE;
        else if (r < 72) act = fas_pkg::ACT_WRITE_DELAY;
        else if (r < 88) act = fas_pkg::ACT_SET_FRAME;
        else act = fas_pkg::ACT_RESTART;
        r = $urandom_range(0, 99);
        if (r < 12) step = fas_pkg::STEP_W'($urandom_range(0, 65535));
        else if (r < 16) step = r[0] ? 16'sh7FFF : 16'sh8000;
        else step = fas_pkg::STEP_W'($urandom_range(0, 4000)) - 16'sd2000;
        r = $urandom_range(0, 99);
        if (r < 8) dval = '0;
        else if (r < 14) dval = r[0] ? 16'hFFFF : fas_pkg::DELAY_W'($urandom_range(0, 65535));
        else if (r < 28) dval = fas_pkg::DELAY_W'($urandom_range(1, 24));
        else dval = fas_pkg::DELAY_W'($urandom_range(40, 2500));
        idx = fas_pkg::FRAME_W'($urandom_range(0, 15));
        if (act == fas_pkg::ACT_ADVANCE) begin
            tries = 0;
            while (trial_walk(step) > WALK_BUDGET && tries < 6) begin
                step = step >>> 3;
                tries++;
            end
            if (trial_walk(step) > WALK_BUDGET) act = fas_pkg::ACT_RESTART;
        end
        send_item(act, step, idx, dval);
    endtask

    // every delay entry written before any walk can read it
    task automatic test_delay_table_fill();
        configure(1'b1, 1'b0, 5'd16);
        for (int i = 0; i < fas_pkg::MAX_FRAMES; i++)
            send_item(fas_pkg::ACT_WRITE_DELAY, fas_pkg::STEP_W'($urandom_range(0, 65535)),
                      fas_pkg::FRAME_W'(i), fas_pkg::DELAY_W'(300 + 25 * i));
    endtask

    // wrap order: extreme steps, set frame past the count, zero delay stop
    task automatic test_normal_order();
        configure(1'b1, 1'b0, 5'd5);
        send_item(fas_pkg::ACT_ADVANCE, 16'sh7FFF, 4'd0, 16'd0);
        send_item(fas_pkg::ACT_ADVANCE, 16'sh8000, 4'd0, 16'd0);
        send_item(fas_pkg::ACT_SET_FRAME, 16'sd0, 4'd15, 16'd0);
        send_item(fas_pkg::ACT_WRITE_DELAY, 16'sd0, 4'd2, 16'd0);
        send_item(fas_pkg::ACT_RESTART, 16'sd0, 4'd0, 16'd0);
        send_item(fas_pkg::ACT_ADVANCE, 16'sd5000, 4'd0, 16'd0);
        send_item(fas_pkg::ACT_ADVANCE, 16'sd100, 4'd0, 16'd0);
        send_item(fas_pkg::ACT_RESTART, 16'sd0, 4'd0, 16'd0);
        send_item(fas_pkg::ACT_WRITE_DELAY, 16'sd0, 4'd2, 16'd350);
    endtask

    // play once: hold at the last frame, clamp at frame 0 going back
    task automatic test_one_shot();
        configure(1'b0, 1'b0, 5'd5);
        send_item(fas_pkg::ACT_ADVANCE, 16'sh7FFF, 4'd0, 16'd0);
        send_item(fas_pkg::ACT_ADVANCE, 16'sh8000, 4'd0, 16'd0);
        configure(1'b0, 1'b1, 5'd5);
        send_item(fas_pkg::ACT_RESTART, 16'sd0, 4'd0, 16'd0);
        send_item(fas_pkg::ACT_ADVANCE, 16'sh7FFF, 4'd0, 16'd0);
        send_item(fas_pkg::ACT_ADVANCE, 16'sh8000, 4'd0, 16'd0);
    endtask

    task automatic test_pingpong_loop();
        configure(1'b1, 1'b1, 5'd5);
        send_item(fas_pkg::ACT_RESTART, 16'sd0, 4'd0, 16'd0);
        send_item(fas_pkg::ACT_ADVANCE, 16'sh7FFF, 4'd0, 16'd0);
        send_item(fas_pkg::ACT_ADVANCE, 16'sh8000, 4'd0, 16'd0);
        send_item(fas_pkg::ACT_ADVANCE, 16'sd1000, 4'd0, 16'd0);
    endtask

    // one frame in use: forward holds still, backward stays on frame 0
    task automatic test_single_frame();
        configure(1'b1, 1'b0, 5'd0);
        send_item(fas_pkg::ACT_RESTART, 16'sd0, 4'd0, 16'd0);
        send_item(fas_pkg::ACT_ADVANCE, 16'sh7FFF, 4'd0, 16'd0);
        send_item(fas_pkg::ACT_ADVANCE, 16'sh8000, 4'd0, 16'd0);
        configure(1'b1, 1'b1, 5'd1);
        send_item(fas_pkg::ACT_ADVANCE, -16'sd2000, 4'd0, 16'd0);
    endtask

    // frame left beyond a shrunk count comes back in on the next advance
    task automatic test_count_shrink();
        configure(1'b1, 1'b0, 5'd31);
        send_item(fas_pkg::ACT_SET_FRAME, 16'sd0, 4'd15, 16'd0);
        configure(1'b0, 1'b1, 5'd4);
        send_item(fas_pkg::ACT_ADVANCE, 16'sd1000, 4'd0, 16'd0);
        configure(1'b1, 1'b0, 5'd16);
        send_item(fas_pkg::ACT_SET_FRAME, 16'sd0, 4'd12, 16'd0);
        configure(1'b1, 1'b0, 5'd3);
        send_item(fas_pkg::ACT_ADVANCE, 16'sd1000, 4'd0, 16'd0);
        send_item(fas_pkg::ACT_WRITE_DELAY, 16'sd0, 4'd15, 16'hFFFF);
    endtask

    // walks on delays of one, long enough to saturate the frames-passed count
    task automatic test_passed_limit();
        configure(1'b1, 1'b0, 5'd1);
        idle_on = 1'b0;
        send_item(fas_pkg::ACT_RESTART, 16'sd0, 4'd0, 16'd0);
        send_item(fas_pkg::ACT_WRITE_DELAY, 16'sd0, 4'd0, 16'd1);
        send_item(fas_pkg::ACT_WRITE_DELAY, 16'sd0, 4'd1, 16'd1);
        // single frame: forward time piles up in the accumulator
        repeat (3) send_item(fas_pkg::ACT_ADVANCE, 16'sh7FFF, 4'd0, 16'd0);
        configure(1'b1, 1'b0, 5'd2);
        send_item(fas_pkg::ACT_ADVANCE, 16'sd0, 4'd0, 16'd0);
        configure(1'b1, 1'b0, 5'd1);
        send_item(fas_pkg::ACT_RESTART, 16'sd0, 4'd0, 16'd0);
        // zero delay: each backward step stops at once, the deficit builds up
        send_item(fas_pkg::ACT_WRITE_DELAY, 16'sd0, 4'd0, 16'd0);
        repeat (3) send_item(fas_pkg::ACT_ADVANCE, 16'sh8000, 4'd0, 16'd0);
        send_item(fas_pkg::ACT_WRITE_DELAY, 16'sd0, 4'd0, 16'd1);
        send_item(fas_pkg::ACT_ADVANCE, -16'sd1, 4'd0, 16'd0);
        send_item(fas_pkg::ACT_RESTART, 16'sd0, 4'd0, 16'd0);
        send_item(fas_pkg::ACT_WRITE_DELAY, 16'sd0, 4'd0, 16'd300);
        send_item(fas_pkg::ACT_WRITE_DELAY, 16'sd0, 4'd1, 16'd325);
        idle_on = 1'b1;
    endtask

    // long receiver hold while items keep coming, then a full drain
    task automatic test_output_backpressure();
        configure(1'b1, 1'b1, 5'd8);
        idle_on      = 1'b0;
        hold_request = 1'b1;
        for (int i = 0; i < 12; i++)
            send_item(fas_pkg::ACT_ADVANCE, fas_pkg::STEP_W'($urandom_range(0, 1500)),
                      4'd0, 16'd0);
        wait_for_results();
        idle_on = 1'b1;
    endtask

    // random items over a series of play modes
    task automatic test_random_items(input int phases, input int per_phase);
        for (int p = 0; p < phases; p++) begin
            case (p)
                0: configure(1'b1, 1'b0, 5'd16);
                1: configure(1'b0, 1'b0, 5'd1);
                2: configure(1'b1, 1'b1, 5'd16);
                3: configure(1'b0, 1'b1, 5'd16);
                4: configure(1'b1, 1'b1, 5'd2);
                5: configure(1'b0, 1'b0, 5'd16);
                6: configure(1'b0, 1'b1, 5'd2);
                7: configure(1'b1, 1'b0, 5'd0);
                8: configure(1'b1, 1'b1, 5'd31);
                default: configure(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                   fas_pkg::CNT_W'($urandom_range(0, 31)));
            endcase
            idle_on = (p % 5 != 2);
            for (int i = 0; i < per_phase; i++) begin
                if (i == per_phase / 2 && p % 3 == 0) wait_for_results();
                send_random_item();
            end
        end
    endtask

    // result side: random stalls, plus one long hold on request
    initial begin : result_taker
        @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!idle_on || $urandom_range(0, 3) != 0) begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b0;
                repeat (idle_gap()) @(posedge i_clk);
            end
        end
    end

    // compare each taken result with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_frame_result want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (expected_frames.size() == 0) begin
                $error("result with no item waiting for it");
                mismatch_count++;
            end else begin
                want = expected_frames.pop_front();
                if (o_frames_passed !== want.passed) begin
                    $error("frames_passed: expected %0d, actual %0d",
                           want.passed, o_frames_passed);
                    mismatch_count++;
                end
                if (o_current_frame_out !== want.frame) begin
                    $error("current_frame_out: expected %0d, actual %0d",
                           want.frame, o_current_frame_out);
                    mismatch_count++;
                end
                if (o_moving_backward !== want.down) begin
                    $error("moving_backward: expected %0d, actual %0d",
                           want.down, o_moving_backward);
                    mismatch_count++;
                end
            end
        end
    end

    // test sequence
    initial begin : stimulus
        mismatch_count = 0;
        idle_on        = 1'b1;
        hold_request   = 1'b0;
        frame_model    = 0;
        acc_model      = 0;
        down_model     = 1'b0;
        loop_model     = 1'b1;
        pingpong_model = 1'b0;
        count_model    = fas_pkg::CNT_W'(1);
        for (int i = 0; i < fas_pkg::MAX_FRAMES; i++) delay_model[i] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_delay_table_fill();
        test_normal_order();
        test_one_shot();
        test_pingpong_loop();
        test_single_frame();
        test_count_shrink();
        test_passed_limit();
        test_output_backpressure();
        test_random_items(14, 120);
        wait_for_results();
        if (mismatch_count == 0) begin
            $display("frame_animation_sequencer_core_test passed");
        end else begin
            $display("frame_animation_sequencer_core_test failed");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/fas_pkg.sv
rtl/core/frame_animation_sequencer_core.sv
verif/frame_animation_sequencer_core_test.sv
